// ----- hw/rtl/magnetometer_iron_calibration_macros.svh -----
// Assertion macros used by the calibration block checker
`ifndef MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define MAGCAL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define MAGCAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// same-cycle implication that also holds through reset
`define MAGCAL_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/magcal_pkg.sv -----
// Shared constants and types for the magnetometer iron calibration block
package magcal_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int COEF_BITS_DEFAULT   = 16;
   localparam int SENTINEL_BITS       = 15;
   localparam int SENTINEL            = 9999;

   localparam int CAL_COUNT_BITS = 16;
   localparam logic [CAL_COUNT_BITS-1:0] CAL_COUNT_RESET = 16'd5000;

   localparam int CORR_BITS = 24;
   localparam int CORR_MAX  = 8388607;
   localparam int CORR_MIN  = -8388608;

   localparam int FUNC_BITS = 2;
   localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_CAL     = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_CORRECT = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW0      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW1      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW2      = 2'd3;

   typedef struct packed {
      logic                 fire;
      logic [FUNC_BITS-1:0] func;
   } magcal_cmd_type;

endpackage

// ----- hw/rtl/magnetometer_iron_calibration.sv -----
// Top level of the magnetometer hard/soft iron calibration block
//
//   Channel  Direction  Handshake                 Beat
//   req      in         req_valid / req_ready     func, raw x/y/z
//   rsp      out        rsp_valid / rsp_ready     corrected x/y/z, offsets_ready, clipped
//   csr      in         csr_we                    cal_count, matrix rows 0..2
//
// One beat per cycle unless rsp stalls; an accepted req reaches rsp via both registers.
// The input register feeds the calibration state and matrix product, whose
// result lands in the output register in the same step.
// Synchronous reset restores identity matrix, cal_count 5000 and clears calibration.
// A stalled rsp holds its register; req_ready drops only when both registers are full.
module magnetometer_iron_calibration
   import magcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int COEF_BITS   = COEF_BITS_DEFAULT,
   localparam int ROW_BITS   = 3 * COEF_BITS,
   localparam int CSR_BITS   = (ROW_BITS > CAL_COUNT_BITS) ? ROW_BITS : CAL_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [FUNC_BITS-1:0]          req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_x,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_y,
   input  logic signed [SAMPLE_BITS-1:0] req_raw_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [CORR_BITS-1:0]   rsp_corr_x,
   output logic signed [CORR_BITS-1:0]   rsp_corr_y,
   output logic signed [CORR_BITS-1:0]   rsp_corr_z,
   output logic                          rsp_offsets_ready,
   output logic                          rsp_clipped,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_BITS-1:0]           csr_wdata
);

   localparam int LIM_BITS = (SAMPLE_BITS > SENTINEL_BITS) ? SAMPLE_BITS : SENTINEL_BITS;
   localparam logic [ROW_BITS-1:0] ONE_ROW = ROW_BITS'(1) << (COEF_BITS - 2);

   logic [CAL_COUNT_BITS-1:0]     cal_count_ff;
   logic [CAL_COUNT_BITS-1:0]     cal_count_in;
   logic [ROW_BITS-1:0]           row_ff [3];
   logic [ROW_BITS-1:0]           row_in [3];

   logic                          valid_a_ff;
   logic                          valid_a_in;
   logic [FUNC_BITS-1:0]          func_a_ff;
   logic [FUNC_BITS-1:0]          func_a_in;
   logic signed [SAMPLE_BITS-1:0] raw_a_ff [3];
   logic signed [SAMPLE_BITS-1:0] raw_a_in [3];

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [CORR_BITS-1:0]   corr_ff [3];
   logic signed [CORR_BITS-1:0]   corr_in [3];
   logic                          ready_flag_ff;
   logic                          ready_flag_in;
   logic                          clipped_ff;
   logic                          clipped_in;

   logic                          advance;
   logic                          fire;
   magcal_cmd_type                cmd;
   logic signed [LIM_BITS:0]      offset_sum [3];
   logic                          latched_next;
   logic signed [CORR_BITS-1:0]   corr [3];
   logic                          clipped;

   always_comb begin
      cal_count_in = cal_count_ff;
      row_in       = row_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAL_COUNT: cal_count_in = csr_wdata[CAL_COUNT_BITS-1:0];
            CSR_ROW0:      row_in[0]    = csr_wdata[ROW_BITS-1:0];
            CSR_ROW1:      row_in[1]    = csr_wdata[ROW_BITS-1:0];
            CSR_ROW2:      row_in[2]    = csr_wdata[ROW_BITS-1:0];
            default:       cal_count_in = cal_count_ff;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !valid_a_ff || advance;
   assign fire      = valid_a_ff && advance;
   assign cmd.fire  = fire;
   assign cmd.func  = func_a_ff;

   always_comb begin
      valid_a_in = valid_a_ff;
      func_a_in  = func_a_ff;
      raw_a_in   = raw_a_ff;
      if (req_ready) begin
         valid_a_in = req_valid;
      end
      if (req_valid && req_ready) begin
         func_a_in   = req_func;
         raw_a_in[0] = req_raw_x;
         raw_a_in[1] = req_raw_y;
         raw_a_in[2] = req_raw_z;
      end
   end

   magcal_tracker #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .LIM_BITS   (LIM_BITS)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .raw         (raw_a_ff),
      .cal_count   (cal_count_ff),
      .offset_sum  (offset_sum),
      .latched_next(latched_next)
   );

   magcal_transform #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS),
      .LIM_BITS   (LIM_BITS)
   ) u_transform (
      .raw       (raw_a_ff),
      .offset_sum(offset_sum),
      .row       (row_ff),
      .corr      (corr),
      .clipped   (clipped)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      corr_in       = corr_ff;
      ready_flag_in = ready_flag_ff;
      clipped_in    = clipped_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         ready_flag_in = latched_next;
         if (func_a_ff == FUNC_CORRECT) begin
            corr_in    = corr;
            clipped_in = clipped;
         end else begin
            for (int i = 0; i < 3; i++) begin
               corr_in[i] = '0;
            end
            clipped_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= CAL_COUNT_RESET;
         row_ff[0]    <= ONE_ROW << (2 * COEF_BITS);
         row_ff[1]    <= ONE_ROW << COEF_BITS;
         row_ff[2]    <= ONE_ROW;
         valid_a_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cal_count_ff <= cal_count_in;
         row_ff       <= row_in;
         valid_a_ff   <= valid_a_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_a_ff     <= func_a_in;
      raw_a_ff      <= raw_a_in;
      corr_ff       <= corr_in;
      ready_flag_ff <= ready_flag_in;
      clipped_ff    <= clipped_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_corr_x        = corr_ff[0];
   assign rsp_corr_y        = corr_ff[1];
   assign rsp_corr_z        = corr_ff[2];
   assign rsp_offsets_ready = ready_flag_ff;
   assign rsp_clipped       = clipped_ff;

endmodule

// ----- hw/rtl/magcal_tracker.sv -----
// Min/max tracking, sample tally and hard-iron offset latch
module magcal_tracker
   import magcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LIM_BITS    = SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  magcal_cmd_type                cmd,
   input  logic signed [SAMPLE_BITS-1:0] raw [3],
   input  logic [CAL_COUNT_BITS-1:0]     cal_count,
   output logic signed [LIM_BITS:0]      offset_sum [3],
   output logic                          latched_next
);

   localparam logic signed [LIM_BITS-1:0] LOW_INIT  = LIM_BITS'(SENTINEL);
   localparam logic signed [LIM_BITS-1:0] HIGH_INIT = LIM_BITS'(-SENTINEL);

   logic signed [LIM_BITS-1:0] low_ff [3];
   logic signed [LIM_BITS-1:0] low_in [3];
   logic signed [LIM_BITS-1:0] high_ff [3];
   logic signed [LIM_BITS-1:0] high_in [3];
   logic signed [LIM_BITS:0]   offset_ff [3];
   logic signed [LIM_BITS:0]   offset_in [3];
   logic [CAL_COUNT_BITS-1:0]  tally_ff;
   logic [CAL_COUNT_BITS-1:0]  tally_in;
   logic                       latched_ff;
   logic                       latched_in;
   logic signed [LIM_BITS-1:0] raw_ext [3];

   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      offset_in  = offset_ff;
      tally_in   = tally_ff;
      latched_in = latched_ff;
      for (int i = 0; i < 3; i++) begin
         raw_ext[i] = LIM_BITS'(raw[i]);
      end
      if (cmd.fire) begin
         unique case (cmd.func)
            FUNC_RESTART: begin
               for (int i = 0; i < 3; i++) begin
                  low_in[i]    = LOW_INIT;
                  high_in[i]   = HIGH_INIT;
                  offset_in[i] = '0;
               end
               tally_in   = '0;
               latched_in = 1'b0;
            end
            FUNC_CAL: begin
               if (!latched_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     if (raw_ext[i] < low_ff[i]) begin
                        low_in[i] = raw_ext[i];
                     end
                     if (raw_ext[i] > high_ff[i]) begin
                        high_in[i] = raw_ext[i];
                     end
                  end
                  tally_in = tally_ff + 1'b1;
                  if ((tally_in >= cal_count) || (tally_in == '0)) begin
                     for (int i = 0; i < 3; i++) begin
                        offset_in[i] = (LIM_BITS+1)'(high_in[i]) + (LIM_BITS+1)'(low_in[i]);
                     end
                     latched_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            low_ff[i]    <= LOW_INIT;
            high_ff[i]   <= HIGH_INIT;
            offset_ff[i] <= '0;
         end
         tally_ff   <= '0;
         latched_ff <= 1'b0;
      end else begin
         low_ff     <= low_in;
         high_ff    <= high_in;
         offset_ff  <= offset_in;
         tally_ff   <= tally_in;
         latched_ff <= latched_in;
      end
   end

   assign offset_sum   = offset_ff;
   assign latched_next = latched_in;

endmodule

// ----- hw/rtl/magcal_transform.sv -----
// Offset removal, soft-iron matrix product, floor and saturation
module magcal_transform
   import magcal_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int COEF_BITS   = COEF_BITS_DEFAULT,
   parameter int LIM_BITS    = SAMPLE_BITS_DEFAULT
) (
   input  logic signed [SAMPLE_BITS-1:0] raw [3],
   input  logic signed [LIM_BITS:0]      offset_sum [3],
   input  logic [3*COEF_BITS-1:0]        row [3],
   output logic signed [CORR_BITS-1:0]   corr [3],
   output logic                          clipped
);

   localparam int TW        = LIM_BITS + 2;
   localparam int PW        = TW + COEF_BITS;
   localparam int AW        = PW + 2;
   localparam int OUT_SHIFT = COEF_BITS - 5;

   localparam logic signed [AW-1:0] SAT_HI = AW'(CORR_MAX);
   localparam logic signed [AW-1:0] SAT_LO = AW'(CORR_MIN);

   logic signed [TW-1:0]        t [3];
   logic signed [COEF_BITS-1:0] c;
   logic signed [PW-1:0]        te;
   logic signed [PW-1:0]        ce;
   logic signed [PW-1:0]        prod;
   logic signed [AW-1:0]        acc;
   logic signed [AW-1:0]        shifted;
   logic [2:0]                  sat;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t[k] = (TW'(raw[k]) <<< 1) - TW'(offset_sum[k]);
      end
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int k = 0; k < 3; k++) begin
            c    = row[i][(2-k)*COEF_BITS +: COEF_BITS];
            te   = PW'(t[k]);
            ce   = PW'(c);
            prod = te * ce;
            acc  = acc + AW'(prod);
         end
         shifted = acc >>> OUT_SHIFT;
         sat[i]  = 1'b0;
         if (shifted > SAT_HI) begin
            corr[i] = CORR_BITS'(CORR_MAX);
            sat[i]  = 1'b1;
         end else if (shifted < SAT_LO) begin
            corr[i] = CORR_BITS'(CORR_MIN);
            sat[i]  = 1'b1;
         end else begin
            corr[i] = shifted[CORR_BITS-1:0];
         end
      end
      clipped = |sat;
   end

endmodule

// ----- hw/rtl/magcal_checker.sv -----
// Port-level checker for the calibration block, bound to the top level
`include "magnetometer_iron_calibration_macros.svh"

module magcal_checker
   import magcal_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [CORR_BITS-1:0] rsp_corr_x,
   input logic signed [CORR_BITS-1:0] rsp_corr_y,
   input logic signed [CORR_BITS-1:0] rsp_corr_z,
   input logic                        rsp_offsets_ready,
   input logic                        rsp_clipped
);

   localparam logic signed [CORR_BITS-1:0] HI = CORR_BITS'(CORR_MAX);
   localparam logic signed [CORR_BITS-1:0] LO = CORR_BITS'(CORR_MIN);

   `MAGCAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_corr_x) && $stable(rsp_corr_y) && $stable(rsp_corr_z) && $stable(rsp_offsets_ready) && $stable(rsp_clipped), "rsp beat changed while stalled")
   `MAGCAL_ASSERT_IMPL(a_clip_at_rail, rsp_valid && rsp_clipped, rsp_corr_x == HI || rsp_corr_x == LO || rsp_corr_y == HI || rsp_corr_y == LO || rsp_corr_z == HI || rsp_corr_z == LO, "clip flag without a saturated axis")
   `MAGCAL_ASSERT_IMPL(a_ready_when_drained, !rsp_valid, req_ready, "req stalled with an empty output register")
   `MAGCAL_ASSERT_ALWAYS(a_reset_empty, $past(reset), !rsp_valid, "rsp valid straight after reset")

endmodule

bind magnetometer_iron_calibration magcal_checker u_magcal_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_corr_x       (rsp_corr_x),
   .rsp_corr_y       (rsp_corr_y),
   .rsp_corr_z       (rsp_corr_z),
   .rsp_offsets_ready(rsp_offsets_ready),
   .rsp_clipped      (rsp_clipped)
);
